@@ sv/swm_pkg.sv @@
// Shared types, sizes and state codes for the sliding window median filter.
// Depends on nothing; every other file of the block but swm_ram imports it.

package swm_pkg;

  // Window depth and sample width of the block.
  localparam int MaxWindow   = 32;
  localparam int SampleWidth = 32;

  // Width of the window size register.
  localparam int CfgW = 6;

  // Index into a store of MaxWindow entries, and a count that can hold MaxWindow itself.
  localparam int IdxW = (MaxWindow > 1) ? $clog2(MaxWindow) : 1;
  localparam int CntW = $clog2(MaxWindow + 1);

  typedef logic signed [SampleWidth-1:0] sample_t;
  typedef logic [IdxW-1:0]               idx_t;
  typedef logic [CntW-1:0]               cnt_t;

  // Result of the shared compare unit.
  typedef struct packed {
    logic lt;  // operand is below the stored value, signed
    logic eq;  // operand equals the stored value
  } cmp_res_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INS_RD,
    ST_INS_CMP,
    ST_CHECK,
    ST_MED,
    ST_RM_RD,
    ST_RM_CMP
  } swm_state_e;

endpackage

@@ sv/swm_if.sv @@
// Stream interfaces for the sample input and the median output.
// Depends on swm_pkg for the sample type.

interface swm_sample_if import swm_pkg::*; ();
  logic    valid;
  logic    ready;
  sample_t sample;

  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

interface swm_median_if import swm_pkg::*; ();
  logic    valid;
  logic    ready;
  sample_t median;

  modport source (output valid, output median, input ready);
  modport sink (input valid, input median, output ready);
endinterface

@@ sv/swm_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.

module swm_ram #(
  parameter int Width = 32,
  parameter int Depth = 32
) (
  input  logic                                         clk_i,
  input  logic                                         we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                             wdata_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                             rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

@@ sv/swm_cmp.sv @@
// Shared compare unit: signed less-than and equality of one operand
// against a value read from the sorted store. Depends on swm_pkg.

module swm_cmp import swm_pkg::*; (
  input  sample_t  a_i,
  input  sample_t  b_i,
  output cmp_res_t res_o
);

  // Both operands are signed, so the compare is signed.
  always_comb begin
    res_o.lt = (a_i < b_i);
    res_o.eq = (a_i == b_i);
  end

endmodule

@@ sv/sliding_window_median.sv @@
// Sliding window median filter: sequencer, arrival ring and sorted store.
// Depends on swm_pkg, swm_if, swm_ram and swm_cmp.
//
//   Channel        Direction  Payload         Transfer when
//   in_sample_i    in         sample  (s32)   valid && ready
//   out_median_o   out        median  (s32)   valid && ready
//   cfg_we_i       in         cfg_wdata_i(6)  cfg_we_i high while idle
//
// A sample is inserted into the sorted store by a search down from its top; when the window is
// then full, the median is sent and one copy of the oldest sample is searched for and removed.
// Every step is one read of the sorted RAM and one pass through the shared compare unit. The
// input is ready only while the sequencer is idle and no register write is present. Reset
// empties the window and sets the size to one; the RAMs are not cleared. A median waits in the
// output register, and the next median stalls until taken.

module sliding_window_median import swm_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  swm_sample_if.sink          in_sample_i,
  swm_median_if.source        out_median_o,
  input  logic                cfg_we_i,
  input  logic [CfgW-1:0]     cfg_wdata_i
);

  swm_state_e state_q, state_d;

  logic [CfgW-1:0] ksize_q, ksize_d;
  cnt_t            fill_q, fill_d;
  idx_t            ptr_q, ptr_d;
  cnt_t            pos_q, pos_d;
  logic            found_q, found_d;
  sample_t         new_q, new_d;
  sample_t         old_q, old_d;
  sample_t         med_q, med_d;
  logic            out_valid_q, out_valid_d;

  cnt_t     ksize_eff;
  cnt_t     fill_eff;
  idx_t     ptr_eff;
  logic [CntW:0] slot_sum;
  idx_t     slot;
  idx_t     med_addr;
  cnt_t     pos_dec;
  logic     in_xfer;
  logic     out_free;

  logic     ring_we;
  sample_t  ring_rdata;
  logic     srt_we;
  idx_t     srt_waddr;
  sample_t  srt_wdata;
  idx_t     srt_raddr;
  sample_t  srt_rdata;
  sample_t  cmp_a;
  cmp_res_t cmp_res;

  // Effective window size: zero counts as one, large values saturate.
  always_comb begin
    if (ksize_q == '0) begin
      ksize_eff = cnt_t'(1);
    end else if (int'(ksize_q) > MaxWindow) begin
      ksize_eff = cnt_t'(MaxWindow);
    end else begin
      ksize_eff = cnt_t'(ksize_q);
    end
  end

  // A full window at the start of a sample restarts the window.
  assign fill_eff = (fill_q >= ksize_eff) ? '0 : fill_q;
  assign ptr_eff  = (fill_q >= ksize_eff) ? '0 : ptr_q;

  // Ring slot of the new sample, wrapped at the window depth.
  always_comb begin
    slot_sum = {1'b0, cnt_t'(ptr_eff)} + {1'b0, fill_eff};
    if (int'(slot_sum) >= MaxWindow) begin
      slot_sum = slot_sum - (CntW+1)'(MaxWindow);
    end
    slot = slot_sum[IdxW-1:0];
  end

  // Lower median sits at (k-1)/2 of the sorted store.
  always_comb begin
    cnt_t km1;
    km1      = ksize_eff - cnt_t'(1);
    med_addr = idx_t'(km1 >> 1);
  end

  assign pos_dec  = pos_q - cnt_t'(1);
  assign in_xfer  = in_sample_i.valid && in_sample_i.ready;
  assign out_free = !out_valid_q || out_median_o.ready;

  // A register write takes the idle cycle, so no sample transfer happens beside it.
  assign in_sample_i.ready   = (state_q == ST_IDLE) && !cfg_we_i;
  assign out_median_o.valid  = out_valid_q;
  assign out_median_o.median = med_q;

  // Next state of the sequencer.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_xfer && !cfg_we_i) begin
          state_d = ST_INS_RD;
        end
      end
      ST_INS_RD: begin
        state_d = (pos_q == '0) ? ST_CHECK : ST_INS_CMP;
      end
      ST_INS_CMP: begin
        state_d = cmp_res.lt ? ST_INS_RD : ST_CHECK;
      end
      ST_CHECK: begin
        state_d = (fill_q < ksize_eff) ? ST_IDLE : ST_MED;
      end
      ST_MED: begin
        if (out_free) begin
          state_d = ST_RM_RD;
        end
      end
      ST_RM_RD: begin
        state_d = (pos_q < fill_q) ? ST_RM_CMP : ST_IDLE;
      end
      ST_RM_CMP: begin
        state_d = ST_RM_RD;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Datapath controls, RAM ports and register updates.
  always_comb begin
    ksize_d     = ksize_q;
    fill_d      = fill_q;
    ptr_d       = ptr_q;
    pos_d       = pos_q;
    found_d     = found_q;
    new_d       = new_q;
    old_d       = old_q;
    med_d       = med_q;
    out_valid_d = out_valid_q && !out_median_o.ready;
    ring_we     = 1'b0;
    srt_we      = 1'b0;
    srt_waddr   = pos_q[IdxW-1:0];
    srt_wdata   = new_q;
    srt_raddr   = med_addr;
    cmp_a       = new_q;
    case (state_q)
      ST_IDLE: begin
        if (cfg_we_i) begin
          ksize_d = cfg_wdata_i;
          fill_d  = '0;
          ptr_d   = '0;
        end else if (in_xfer) begin
          ring_we = 1'b1;
          new_d   = in_sample_i.sample;
          fill_d  = fill_eff;
          ptr_d   = ptr_eff;
          pos_d   = fill_eff;
        end
      end
      ST_INS_RD: begin
        srt_raddr = pos_dec[IdxW-1:0];
        if (pos_q == '0) begin
          // Insertion reached the bottom of the store.
          srt_we = 1'b1;
          fill_d = fill_q + cnt_t'(1);
        end
      end
      ST_INS_CMP: begin
        srt_we = 1'b1;
        if (cmp_res.lt) begin
          // Move the larger value up one place and keep searching.
          srt_wdata = srt_rdata;
          pos_d     = pos_dec;
        end else begin
          fill_d = fill_q + cnt_t'(1);
        end
      end
      ST_MED: begin
        // Hold the read address so the median stays on the RAM output.
        if (out_free) begin
          med_d       = srt_rdata;
          out_valid_d = 1'b1;
          old_d       = ring_rdata;
          pos_d       = '0;
          found_d     = 1'b0;
        end
      end
      ST_RM_RD: begin
        srt_raddr = pos_q[IdxW-1:0];
        if (pos_q >= fill_q) begin
          fill_d = fill_q - cnt_t'(1);
          ptr_d  = (int'(ptr_q) == MaxWindow - 1) ? '0 : ptr_q + idx_t'(1);
        end
      end
      ST_RM_CMP: begin
        // Past the first copy of the oldest value, close the gap downward.
        cmp_a     = old_q;
        srt_waddr = pos_dec[IdxW-1:0];
        srt_wdata = srt_rdata;
        if (found_q) begin
          srt_we = 1'b1;
        end else if (cmp_res.eq) begin
          found_d = 1'b1;
        end
        pos_d = pos_q + cnt_t'(1);
      end
      default: begin
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ksize_q     <= CfgW'(1);
      fill_q      <= '0;
      ptr_q       <= '0;
      pos_q       <= '0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ksize_q     <= ksize_d;
      fill_q      <= fill_d;
      ptr_q       <= ptr_d;
      pos_q       <= pos_d;
      found_q     <= found_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    new_q <= new_d;
    old_q <= old_d;
    med_q <= med_d;
  end

  // Samples in arrival order; always read at the oldest slot.
  swm_ram #(
    .Width (SampleWidth),
    .Depth (MaxWindow)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (ring_we),
    .waddr_i (slot),
    .wdata_i (in_sample_i.sample),
    .raddr_i (ptr_q),
    .rdata_o (ring_rdata)
  );

  // Window samples in ascending signed order.
  swm_ram #(
    .Width (SampleWidth),
    .Depth (MaxWindow)
  ) u_sorted (
    .clk_i   (clk_i),
    .we_i    (srt_we),
    .waddr_i (srt_waddr),
    .wdata_i (srt_wdata),
    .raddr_i (srt_raddr),
    .rdata_o (srt_rdata)
  );

  // One compare unit serves both insertion and removal.
  swm_cmp u_cmp (
    .a_i   (cmp_a),
    .b_i   (srt_rdata),
    .res_o (cmp_res)
  );

endmodule

@@ sim/swm_median_checker.sv @@
// Checker for the sliding window median filter: watches the sample, median and
// register ports, predicts each median and compares it with what the block sends.
// Depends on swm_pkg and on the stream interfaces in swm_if.

module swm_median_checker import swm_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  swm_sample_if           in_mon,
  swm_median_if           out_mon,
  input  logic            cfg_we_i,
  input  logic [CfgW-1:0] cfg_wdata_i,
  output int              fail_count_o,
  output int              pending_o,
  output int              medians_seen_o
);

  // Predictor state: the window in arrival order and in ascending order.
  sample_t         ring_mem   [MaxWindow];
  sample_t         sorted_mem [MaxWindow];
  int unsigned     fill;
  int unsigned     oldest;
  logic [CfgW-1:0] win_size;

  // Medians predicted but not yet seen on the output.
  sample_t         median_fifo [$];

  // A size of zero acts as one, and sizes above the depth saturate.
  function automatic int unsigned active_span(input logic [CfgW-1:0] w);
    if (w == 0) return 1;
    if (w > MaxWindow) return MaxWindow;
    return 32'(w);
  endfunction

  // Adds one sample to the window and queues the median when the window is full.
  task automatic predict_median(input sample_t s);
    int unsigned span;
    int          pos;
    int          hit;
    int          i;
    sample_t     gone;
    span = active_span(win_size);
    if (fill >= span) begin
      fill   = 0;
      oldest = 0;
    end
    ring_mem[(oldest + fill) % MaxWindow] = s;

    // Equal values stay ahead of the new sample.
    pos = fill;
    while (pos > 0 && s < sorted_mem[pos-1]) begin
      sorted_mem[pos] = sorted_mem[pos-1];
      pos--;
    end
    sorted_mem[pos] = s;
    fill++;
    if (fill < span) return;

    median_fifo = {median_fifo, sorted_mem[(span - 1) / 2]};

    // Drop one copy of the oldest value from the sorted window.
    gone = ring_mem[oldest];
    hit  = -1;
    for (i = 0; i < fill; i++) begin
      if (hit < 0 && sorted_mem[i] == gone) hit = i;
    end
    if (hit >= 0) begin
      for (i = hit; i + 1 < fill; i++) sorted_mem[i] = sorted_mem[i+1];
    end
    fill--;
    oldest = (oldest + 1) % MaxWindow;
  endtask

  // Register writes come first, then the median transfer, then the sample transfer.
  always @(posedge clk_i or negedge rst_ni) begin : watch
    sample_t want;
    if (!rst_ni) begin
      fill           = 0;
      oldest         = 0;
      win_size       = CfgW'(1);
      median_fifo.delete();
      fail_count_o   = 0;
      pending_o      = 0;
      medians_seen_o = 0;
    end else begin
      if (cfg_we_i) begin
        win_size = cfg_wdata_i;
        fill     = 0;
        oldest   = 0;
      end
      if (out_mon.valid && out_mon.ready) begin
        medians_seen_o++;
        if (median_fifo.size() == 0) begin
          $display("%0t: median %0d arrived with none expected", $time, out_mon.median);
          fail_count_o++;
        end else begin
          want = median_fifo.pop_front();
          if (want !== out_mon.median) begin
            $display("%0t: median mismatch, expected %0d, got %0d",
                     $time, want, out_mon.median);
            fail_count_o++;
          end
        end
      end
      if (in_mon.valid && in_mon.ready) predict_median(in_mon.sample);
      pending_o = median_fifo.size();
    end
  end

endmodule

@@ sim/tb_sliding_window_median.sv @@
// Top of the median filter testbench: clock, reset, sample and register stimulus
// and the verdict. Depends on swm_pkg, swm_if, the block and swm_median_checker.

module tb_sliding_window_median import swm_pkg::*; ();

  localparam int      LimitCycles  = 1500000;
  localparam int      SettleCycles = 200;
  localparam sample_t SMax = {1'b0, {(SampleWidth-1){1'b1}}};
  localparam sample_t SMin = {1'b1, {(SampleWidth-1){1'b0}}};

  logic            clk_i;
  logic            rst_ni;
  logic            cfg_we;
  logic [CfgW-1:0] cfg_wdata;

  int fails;
  int pending;
  int medians;
  int sent;
  int writes;
  int cycle_cnt = 0;
  bit steady;

  swm_sample_if sample_if ();
  swm_median_if median_if ();

  sliding_window_median i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_sample_i  (sample_if),
    .out_median_o (median_if),
    .cfg_we_i     (cfg_we),
    .cfg_wdata_i  (cfg_wdata)
  );

  swm_median_checker i_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_mon         (sample_if),
    .out_mon        (median_if),
    .cfg_we_i       (cfg_we),
    .cfg_wdata_i    (cfg_wdata),
    .fail_count_o   (fails),
    .pending_o      (pending),
    .medians_seen_o (medians)
  );

  // Free-running clock with a period of 10.
  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == LimitCycles) begin
      $display("tb_sliding_window_median failed");
      $finish;
    end
  end

  // Stall lengths: mostly short, now and then a long one.
  function automatic int stall_len();
    if ($urandom_range(0, 19) < 16) return $urandom_range(1, 3);
    return $urandom_range(15, 60);
  endfunction

  // Gap after a sample transfer; none at all while the run is steady.
  function automatic int input_gap();
    if (steady || $urandom_range(0, 1) == 0) return 0;
    return stall_len();
  endfunction

  // Random samples: full range, small values that repeat, and values near the ends.
  function automatic sample_t make_sample();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 5) return sample_t'($urandom);
    if (r < 8) return sample_t'(int'($urandom_range(0, 16)) - 8);
    if (r == 8) return SMin + sample_t'($urandom_range(0, 2));
    return SMax - sample_t'($urandom_range(0, 2));
  endfunction

  // Output side: ready drops at random, except while the run is steady.
  initial begin : ready_drive
    int stall;
    stall           = 0;
    median_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (stall > 0) begin
        median_if.ready <= 1'b0;
        stall--;
      end else begin
        median_if.ready <= 1'b1;
        if (!steady && $urandom_range(0, 9) < 3) stall = stall_len();
      end
    end
  end

  // Offers one sample and returns at the falling edge after its transfer.
  task automatic send_sample(input sample_t s, input int gap);
    sample_if.valid  <= 1'b1;
    sample_if.sample <= s;
    @(posedge clk_i);
    while (!sample_if.ready) @(posedge clk_i);
    @(negedge clk_i);
    sent++;
    if (gap > 0) begin
      sample_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
  endtask

  // Writes the window size once the block has drained and gone quiet.
  task automatic write_size(input logic [CfgW-1:0] v);
    sample_if.valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk_i);
    cfg_we <= 1'b0;
    writes++;
  endtask

  // Stimulus: directed samples first, then random phases at many window sizes.
  initial begin : stimulus
    logic [CfgW-1:0] plan [10];
    logic [CfgW-1:0] sz;
    int              span;
    int              count;
    int              p;
    plan = '{6'd2, 6'd63, 6'd5, 6'd0, 6'd32, 6'd8, 6'd13, 6'd33, 6'd7, 6'd1};
    rst_ni           = 1'b0;
    cfg_we           = 1'b0;
    cfg_wdata        = '0;
    sample_if.valid  = 1'b0;
    sample_if.sample = '0;
    sent             = 0;
    writes           = 0;
    steady           = 1'b0;
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Size one after reset: each sample is its own median.
    send_sample(SMax, input_gap());
    send_sample(SMin, input_gap());
    send_sample('0, input_gap());
    send_sample(-1, input_gap());

    // Odd window with repeated extremes; two samples are left behind on purpose.
    write_size(6'd3);
    send_sample(SMin, input_gap());
    send_sample(SMax, input_gap());
    send_sample(SMin, input_gap());
    send_sample(SMin, input_gap());
    send_sample(SMax, input_gap());
    send_sample('0, input_gap());

    // Even window with equal values: the lower middle value is taken.
    write_size(6'd4);
    send_sample(5, input_gap());
    send_sample(5, input_gap());
    send_sample(-5, input_gap());
    send_sample(5, input_gap());
    send_sample(-5, input_gap());
    send_sample(5, input_gap());

    // A size of zero behaves like one.
    write_size(6'd0);
    send_sample(7, input_gap());
    send_sample(-7, input_gap());

    // Random phases; large windows are slow, so they get fewer samples.
    for (p = 0; p <= 10; p++) begin
      sz     = (p == 10) ? 6'($urandom_range(0, 63)) : plan[p];
      span   = (sz == 0) ? 1 : ((sz > MaxWindow) ? MaxWindow : int'(sz));
      count  = (span >= 16) ? 60 : 110;
      write_size(sz);
      steady = (p % 4 == 1);
      repeat (count) send_sample(make_sample(), input_gap());
      steady = 1'b0;
    end

    // Drain the last medians and let the block settle.
    sample_if.valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);

    $display("Sent %0d samples across %0d window size writes, from zero to oversized.",
             sent, writes);
    $display("Checked %0d medians; %0d mismatches or unexpected medians.", medians, fails);
    if (fails == 0 && pending == 0) begin
      $display("tb_sliding_window_median passed");
    end else begin
      $display("tb_sliding_window_median failed");
    end
    $finish;
  end

endmodule
